// ===== rtl/psarw_pkg.sv =====
// psarw_pkg: shared types and codes for the per-source anti-replay window
`timescale 1ns / 1ps
`default_nettype none
package psarw_pkg;

  // item opcodes
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // sequence distance of exactly half the number space is neither newer nor older
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  // one table entry as it travels along the ring of cells
  typedef struct packed {
    logic        in_use;
    logic [31:0] key;
    logic [31:0] highest_seq;
    logic [31:0] window;
    logic [31:0] last_seen;
  } entry_t;

  // control shared by every cell in the ring
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage : psarw_pkg
`default_nettype wire

// ===== rtl/per_source_anti_replay_window.sv =====
// per_source_anti_replay_window: top level, ring of slot cells plus head sequencer
// flow: a check item makes two full rotations of the cell ring (lookup pass,
//   write-back pass); a clear item or an empty key skips both passes;
//   next start may follow once busy falls; the receiver cannot stall
// reset: synchronous rst_n empties every slot at once and holds out_strobe low
`timescale 1ns / 1ps
`default_nettype none
module per_source_anti_replay_window #(
  parameter int TABLE_SLOTS = 16,
  parameter int WIN_WIDTH   = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // item channel
  input  wire         start,
  output logic        busy,
  input  wire         in_mode,
  input  wire  [31:0] in_source_key,
  input  wire  [31:0] in_sequence_req,
  input  wire  [31:0] in_now_ticks,
  // result channel, one strobe per item, cannot be stalled
  output logic        out_strobe,
  output logic        out_accepted
);
  import psarw_pkg::*;

  // the table rotates by one slot per cycle during a pass; the last cell
  // feeds the head logic, whose output re-enters the first cell
  entry_t    ents [TABLE_SLOTS];
  entry_t    head_out;
  cell_ctl_t ctl;

  genvar p;
  generate
    for (p = 0; p < TABLE_SLOTS; p++) begin : g_cell
      entry_t cell_in;
      if (p == 0) begin : g_first
        assign cell_in = head_out;
      end else begin : g_rest
        assign cell_in = ents[p-1];
      end
      psarw_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .ent_in  (cell_in),
        .ent_out (ents[p])
      );
    end
  endgenerate

  // sequencer: lookup, free-slot and idle-age search on the first pass,
  // modification of the chosen slot on the second
  psarw_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .WIN_WIDTH   (WIN_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_source_key   (in_source_key),
    .in_sequence_req (in_sequence_req),
    .in_now_ticks    (in_now_ticks),
    .out_strobe      (out_strobe),
    .out_accepted    (out_accepted),
    .head_in         (ents[TABLE_SLOTS-1]),
    .head_out        (head_out),
    .ctl             (ctl)
  );

endmodule : per_source_anti_replay_window
`default_nettype wire

// ===== rtl/psarw_cell.sv =====
// psarw_cell: one source slot of the rotating table
`timescale 1ns / 1ps
`default_nettype none
module psarw_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire psarw_pkg::cell_ctl_t ctl,
  input  wire psarw_pkg::entry_t    ent_in,
  output psarw_pkg::entry_t         ent_out
);
  import psarw_pkg::*;

  logic        in_use_r;
  logic [31:0] key_r;
  logic [31:0] highest_seq_r;
  logic [31:0] window_r;
  logic [31:0] last_seen_r;

  // valid flag: cleared by reset and clear items
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      in_use_r <= 1'b0;
    end else if (ctl.shift) begin
      in_use_r <= ent_in.in_use;
    end
  end

  // payload of the slot, taken from the neighbor on each shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r         <= ent_in.key;
      highest_seq_r <= ent_in.highest_seq;
      window_r      <= ent_in.window;
      last_seen_r   <= ent_in.last_seen;
    end
  end

  assign ent_out.in_use      = in_use_r;
  assign ent_out.key         = key_r;
  assign ent_out.highest_seq = highest_seq_r;
  assign ent_out.window      = window_r;
  assign ent_out.last_seen   = last_seen_r;

endmodule : psarw_cell
`default_nettype wire

// ===== rtl/psarw_ctrl.sv =====
// psarw_ctrl: sequencer and head-of-ring lookup, eviction and window update
`timescale 1ns / 1ps
`default_nettype none
module psarw_ctrl #(
  parameter int TABLE_SLOTS = 16,
  parameter int WIN_WIDTH   = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire                       in_mode,
  input  wire  [31:0]               in_source_key,
  input  wire  [31:0]               in_sequence_req,
  input  wire  [31:0]               in_now_ticks,
  output logic                      out_strobe,
  output logic                      out_accepted,
  input  wire psarw_pkg::entry_t    head_in,
  output psarw_pkg::entry_t         head_out,
  output psarw_pkg::cell_ctl_t      ctl
);
  import psarw_pkg::*;

  localparam int          IDX_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [31:0] WIN_MASK = 32'hFFFF_FFFF >> (32 - WIN_WIDTH);
  localparam logic [31:0] WIN_LEN  = 32'(WIN_WIDTH);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic [31:0]      old_age_r, old_age_nxt;
  logic             acc_r, acc_nxt;
  logic             strobe_r, strobe_nxt;
  logic             result_r, result_nxt;

  logic [IDX_W-1:0] target;
  logic [31:0]      age;
  logic [31:0]      ahead;
  logic [31:0]      behind;
  logic [31:0]      win_shift;
  logic             newer;
  logic             older_ok;
  entry_t           upd_ent;
  logic             upd_acc;

  // slot chosen for the update pass: match, else first free, else idle longest
  always_comb begin
    if (found_r) begin
      target = hit_r;
    end else if (free_found_r) begin
      target = free_r;
    end else begin
      target = old_idx_r;
    end
  end

  assign age       = now_r - head_in.last_seen;
  assign ahead     = seq_r - head_in.highest_seq;
  assign behind    = head_in.highest_seq - seq_r;
  assign win_shift = head_in.window << ahead[4:0];
  assign newer     = (ahead != 32'd0) && (ahead < HALF_RANGE);
  assign older_ok  = (ahead != 32'd0) && (behind < HALF_RANGE) && (behind < WIN_LEN)
                     && !head_in.window[behind[4:0]];

  // new contents of the target slot and the verdict
  always_comb begin
    upd_ent = head_in;
    upd_acc = 1'b0;
    if (!found_r) begin
      upd_ent.in_use      = 1'b1;
      upd_ent.key         = key_r;
      upd_ent.highest_seq = seq_r;
      upd_ent.window      = 32'd1 & WIN_MASK;
      upd_ent.last_seen   = now_r;
      upd_acc             = 1'b1;
    end else if (newer) begin
      if (ahead >= WIN_LEN) begin
        upd_ent.window = 32'd1;
      end else begin
        upd_ent.window = (win_shift | 32'd1) & WIN_MASK;
      end
      upd_ent.highest_seq = seq_r;
      upd_ent.last_seen   = now_r;
      upd_acc             = 1'b1;
    end else if (older_ok) begin
      upd_ent.window    = (head_in.window | (32'd1 << behind[4:0])) & WIN_MASK;
      upd_ent.last_seen = now_r;
      upd_acc           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    seq_r        <= seq_nxt;
    now_r        <= now_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    old_idx_r    <= old_idx_nxt;
    old_age_r    <= old_age_nxt;
    acc_r        <= acc_nxt;
    result_r     <= result_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    seq_nxt        = seq_r;
    now_nxt        = now_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    old_idx_nxt    = old_idx_r;
    old_age_nxt    = old_age_r;
    acc_nxt        = acc_r;
    strobe_nxt     = 1'b0;
    result_nxt     = result_r;
    ctl            = '0;
    head_out       = head_in;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt        = in_source_key;
          seq_nxt        = in_sequence_req;
          now_nxt        = in_now_ticks;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          acc_nxt        = 1'b0;
          if (in_mode == MODE_CLEAR) begin
            ctl.clear  = 1'b1;
            strobe_nxt = 1'b1;
            result_nxt = 1'b0;
          end else if (in_source_key == 32'd0) begin
            strobe_nxt = 1'b1;
            result_nxt = 1'b0;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        ctl.shift = 1'b1;
        if (!found_r && head_in.in_use && head_in.key == key_r) begin
          found_nxt = 1'b1;
          hit_nxt   = cnt_r;
        end
        if (!free_found_r && !head_in.in_use) begin
          free_found_nxt = 1'b1;
          free_nxt       = cnt_r;
        end
        if (cnt_r == '0 || age > old_age_r) begin
          old_idx_nxt = cnt_r;
          old_age_nxt = age;
        end
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_UPDATE: begin
        ctl.shift = 1'b1;
        if (cnt_r == target) begin
          head_out = upd_ent;
          acc_nxt  = upd_acc;
        end
        if (cnt_r == LAST_IDX) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          result_nxt = (cnt_r == target) ? upd_acc : acc_r;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_strobe   = strobe_r;
  assign out_accepted = result_r;

endmodule : psarw_ctrl
`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for the per-source anti-replay window
`timescale 1ns / 1ps

import psarw_pkg::*;

// table model plus the queue of verdicts still owed by the block
class verdict_scoreboard;
  localparam int SLOTS = 16;
  localparam int WIN_W = 32;
  localparam logic [31:0] WIN_MASK = 32'hFFFF_FFFF >> (32 - WIN_W);

  bit          occupied [SLOTS];
  logic [31:0] owner    [SLOTS];
  logic [31:0] top_seq  [SLOTS];
  logic [31:0] seen_map [SLOTS];
  logic [31:0] stamp    [SLOTS];

  logic verdict_q[$];
  int   errors;
  int   results_checked;
  int   fresh_count;
  int   clears;
  int   evictions;

  function new();
    wipe();
    errors = 0;
    results_checked = 0;
    fresh_count = 0;
    clears = 0;
    evictions = 0;
  endfunction

  function void wipe();
    for (int i = 0; i < SLOTS; i++) begin
      occupied[i] = 1'b0;
      owner[i]    = '0;
      top_seq[i]  = '0;
      seen_map[i] = '0;
      stamp[i]    = '0;
    end
  endfunction

  // freshness decision for one packet, updating the table when accepted
  function logic judge_packet(logic [31:0] key, logic [31:0] seq, logic [31:0] now);
    int          hit;
    int          victim;
    logic [31:0] ahead;
    logic [31:0] behind;
    logic [31:0] age;
    logic [31:0] oldest_age;
    hit = -1;
    victim = -1;
    if (key == '0) return 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && occupied[i] && owner[i] == key) hit = i;
    end
    if (hit < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (victim < 0 && !occupied[i]) victim = i;
      end
      // table full: the entry idle longest goes, lowest index on ties
      if (victim < 0) begin
        victim = 0;
        oldest_age = now - stamp[0];
        for (int i = 1; i < SLOTS; i++) begin
          age = now - stamp[i];
          if (age > oldest_age) begin
            victim = i;
            oldest_age = age;
          end
        end
        evictions++;
      end
      occupied[victim] = 1'b1;
      owner[victim]    = key;
      top_seq[victim]  = seq;
      seen_map[victim] = 32'd1 & WIN_MASK;
      stamp[victim]    = now;
      return 1'b1;
    end
    ahead = seq - top_seq[hit];
    if (ahead == '0) return 1'b0;
    if (ahead < HALF_RANGE) begin
      if (ahead >= WIN_W) seen_map[hit] = 32'd1;
      else seen_map[hit] = ((seen_map[hit] << ahead) | 32'd1) & WIN_MASK;
      top_seq[hit] = seq;
      stamp[hit]   = now;
      return 1'b1;
    end
    behind = top_seq[hit] - seq;
    if (behind >= HALF_RANGE || behind >= WIN_W) return 1'b0;
    if (seen_map[hit][behind[4:0]]) return 1'b0;
    seen_map[hit] = (seen_map[hit] | (32'd1 << behind)) & WIN_MASK;
    stamp[hit] = now;
    return 1'b1;
  endfunction

  function void note_item(logic mode, logic [31:0] key, logic [31:0] seq, logic [31:0] now);
    logic verdict;
    if (mode == MODE_CLEAR) begin
      wipe();
      clears++;
      verdict = 1'b0;
    end else begin
      verdict = judge_packet(key, seq, now);
    end
    verdict_q.push_back(verdict);
  endfunction

  function void check_result(logic got);
    logic want;
    if (verdict_q.size() == 0) begin
      $display("%0t: result with nothing outstanding, expected none, got accepted=%0b",
               $time, got);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    results_checked++;
    if (got !== want) begin
      $display("%0t: accepted mismatch, expected %0b, got %0b", $time, want, got);
      errors++;
    end else if (got) begin
      fresh_count++;
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module tb;
  localparam int POOL_KEYS    = 20;     // a few more senders than table slots
  localparam int PHASE_ITEMS  = 577;
  localparam int CYCLE_LIMIT  = 900000;
  localparam int DRAIN_CYCLES = 40;     // a little over one check item's latency

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_mode = MODE_CHECK;
  logic [31:0] in_source_key = '0;
  logic [31:0] in_sequence_req = '0;
  logic [31:0] in_now_ticks = '0;
  logic        busy;
  logic        out_strobe;
  logic        out_accepted;

  verdict_scoreboard bank = new();

  // stimulus-side view of the senders: keys and a running sequence per key
  logic [31:0] pool_key [POOL_KEYS];
  logic [31:0] pool_seq [POOL_KEYS];
  logic [31:0] tick_now = '0;
  int          sender_idle_pct = 0;
  int          items_sent = 0;

  per_source_anti_replay_window uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_source_key  (in_source_key),
    .in_sequence_req(in_sequence_req),
    .in_now_ticks   (in_now_ticks),
    .out_strobe     (out_strobe),
    .out_accepted   (out_accepted)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
             $time, CYCLE_LIMIT, bank.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // result monitor: a strobe is one item's verdict, it cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) bank.check_result(out_accepted);
  end

  // present one item and hold it until the block takes it (start high, busy low)
  task automatic send_item(input logic mode, input logic [31:0] key,
                           input logic [31:0] seq, input logic [31:0] now);
    int gap;
    gap = 0;
    if (sender_idle_pct > 0) begin
      while ($urandom_range(99) < sender_idle_pct) gap++;
      // occasional long pause so start rises at any point of a busy stretch
      if ($urandom_range(9) == 0) gap += $urandom_range(1, 45);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_source_key   <= key;
    in_sequence_req <= seq;
    in_now_ticks    <= now;
    do @(posedge clk); while (busy !== 1'b0);
    bank.note_item(mode, key, seq, now);
    items_sent++;
  endtask

  task automatic check_pkt(input logic [31:0] key, input logic [31:0] seq,
                           input logic [31:0] now);
    send_item(MODE_CHECK, key, seq, now);
  endtask

  // hand-picked items: edges of the fields and each corner of the window rules
  task automatic directed_items();
    logic [31:0] ka;
    logic [31:0] kb;
    ka = 32'h0000_0001;
    kb = 32'h8000_0000;
    send_item(MODE_CLEAR, '0, '0, '0);                  // clear on an empty table
    check_pkt('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);         // empty key, always rejected
    check_pkt(ka, 32'd100, 32'd10);                      // first packet of a new source
    check_pkt(ka, 32'd100, 32'd11);                      // same as highest: duplicate
    check_pkt(ka, 32'd101, 32'd12);                      // one ahead
    check_pkt(ka, 32'd99, 32'd13);                       // older, bit still clear
    check_pkt(ka, 32'd99, 32'd14);                       // older, now a replay
    check_pkt(ka, 32'd133, 32'd15);                      // jump of a full window width
    check_pkt(ka, 32'd102, 32'd16);                      // deepest bit of the window
    check_pkt(ka, 32'd101, 32'd17);                      // one past the window: too old
    check_pkt(ka, 32'd133 + HALF_RANGE, 32'd18);         // exactly half the range away
    check_pkt(ka, 32'd164, 32'd19);                      // shift by window width minus one
    check_pkt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_pkt(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);  // wraps to newer by one
    check_pkt(kb, 32'h0000_0000, 32'h0000_0000);
    check_pkt(kb, 32'h7FFF_FFFF, 32'h0000_0001);         // largest step still newer
    check_pkt(kb, 32'hFFFF_FFFF, 32'h0000_0002);         // half range behind: rejected
    send_item(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_pkt(ka, 32'd50, 32'd20);                       // source forgotten after clear
    check_pkt(ka, 32'd18, 32'd21);                       // window edge after a restart
  endtask

  // mostly plausible traffic per sender, with replays, edges and some noise
  task automatic random_items(input int count);
    int          pick;
    int          idx;
    int          kind;
    logic [31:0] seq;
    for (int n = 0; n < count; n++) begin
      // time mostly creeps forward; repeats give eviction ties, rare jumps wrap ages
      if ($urandom_range(99) < 3) tick_now = $urandom;
      else if ($urandom_range(3) != 0) tick_now = tick_now + $urandom_range(1, 200);
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_item(MODE_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 5) begin
        check_pkt('0, $urandom, tick_now);
      end else if (pick < 9) begin
        check_pkt($urandom, $urandom, tick_now);
      end else begin
        idx  = $urandom_range(POOL_KEYS - 1);
        kind = $urandom_range(99);
        seq  = pool_seq[idx];
        if (kind < 30) seq = seq + $urandom_range(1, 31);
        else if (kind < 38) seq = seq + $urandom_range(31, 33);
        else if (kind < 45) seq = seq + $urandom_range(34, 32'h7FFF_FFFF);
        else if (kind < 70) seq = seq - $urandom_range(1, 31);
        else if (kind < 76) seq = seq;
        else if (kind < 82) seq = seq - $urandom_range(32, 33);
        else if (kind < 86) seq = seq + HALF_RANGE;
        else if (kind < 90) seq = seq - $urandom_range(34, 32'h7FFF_FFFF);
        else seq = $urandom;
        // newer steps advance the sender's running sequence
        if (kind < 45) pool_seq[idx] = seq;
        check_pkt(pool_key[idx], seq, tick_now);
      end
    end
  endtask

  initial begin
    // distinct nonzero keys by their low bits, random above
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_key[i] = ($urandom & 32'hFFFF_FFE0) | (i + 1);
      pool_seq[i] = $urandom;
    end
    pool_seq[0] = 32'hFFFF_FFF0;   // one sender crosses the wrap early

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();

    // sender idles often, then very often, then never
    sender_idle_pct = 28;
    random_items(PHASE_ITEMS);
    sender_idle_pct = 60;
    random_items(PHASE_ITEMS);
    sender_idle_pct = 0;
    random_items(PHASE_ITEMS);

    start <= 1'b0;
    while (bank.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d verdicts checked, %0d accepted as fresh",
             items_sent, bank.results_checked, bank.fresh_count);
    $display("table cleared %0d times, %0d sources evicted, %0d mismatches",
             bank.clears, bank.evictions, bank.errors);
    if (bank.errors == 0 && bank.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/psarw_pkg.sv
rtl/psarw_cell.sv
rtl/psarw_ctrl.sv
rtl/per_source_anti_replay_window.sv
test/tb.sv
